// ===== rtl/erf_rational_approx_macros.svh =====
// Assertion macros for the error function pipeline.
// Needs a clock named clk and an active-high reset named rst in the including scope.
`ifndef ERF_RATIONAL_APPROX_MACROS_SVH
`define ERF_RATIONAL_APPROX_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ERF_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("erf pipeline check failed in the same cycle");

// The condition must hold in the cycle after the trigger.
`define ERF_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("erf pipeline check failed one cycle later");

`endif

// ===== rtl/erf_ra_pkg.sv =====
// Shared constants, types and arithmetic steps of the error function pipeline.
// Stands alone; the top level erf_rational_approx imports it.
package erf_ra_pkg;

  localparam int DEF_INPUT_WIDTH  = 16;
  localparam int DEF_OUTPUT_WIDTH = 16;

  // Input fraction bits and the width the input is sign-extended to.
  localparam int IN_FRAC = 12;
  localparam int XW      = 33;

  // |x| on the polynomial path never exceeds six, so fifteen bits hold it.
  localparam int ZW = 15;

  // Horner accumulator: unsigned, 32 fraction bits, value below sixteen.
  localparam int ACC_W  = 36;
  localparam int PROD_W = ZW + ACC_W;
  localparam logic [PROD_W-1:0] IN_HALF = PROD_W'(1) << (IN_FRAC - 1);

  // Reciprocal and its powers: 31 fraction bits, value at most one.
  localparam int R_W     = 32;
  localparam int SQ_FRAC = R_W - 1;
  localparam logic [2*R_W-1:0] SQ_HALF = (2*R_W)'(1) << (SQ_FRAC - 1);
  localparam logic [R_W-1:0]   ONE_Q31 = {1'b1, (R_W-1)'(0)};

  localparam int HORNER_STEPS        = 6;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = R_W / DIV_STEPS_PER_STAGE;
  localparam int SQUARINGS           = 4;

  // Beyond plus or minus six the result saturates.
  localparam logic signed [XW-1:0] LIMIT_POS = XW'(6 << IN_FRAC);
  localparam logic signed [XW-1:0] LIMIT_NEG = -LIMIT_POS;

  // Polynomial coefficients a0 to a6, each round(a * 2^32).
  localparam logic [ACC_W-1:0] COEF_Q32 [HORNER_STEPS+1] = '{
    36'd4294967296,
    36'd302894315,
    36'd181599860,
    36'd39816611,
    36'd652896,
    36'd1187847,
    36'd184958
  };

  typedef struct packed {
    logic neg;
    logic sat_pos;
    logic sat_neg;
  } side_t;

  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [R_W-1:0]   qn;
  } div_t;

  // One Horner step: coef + round(z * acc / 2^12).
  function automatic logic [ACC_W-1:0] horner_step(input logic [ZW-1:0]    z,
                                                   input logic [ACC_W-1:0] acc,
                                                   input logic [ACC_W-1:0] coef);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(z) * PROD_W'(acc) + IN_HALF;
    return coef + ACC_W'(prod >> IN_FRAC);
  endfunction

  // Restoring division steps. The low numerator bits sit in qn and are shifted
  // out at the top while the quotient bits enter at the bottom.
  function automatic div_t div_stage(input logic [ACC_W-1:0] rem,
                                     input logic [R_W-1:0]   qn,
                                     input logic [ACC_W-1:0] den);
    logic [ACC_W:0] trial;
    div_t res;
    res.rem = rem;
    res.qn  = qn;
    for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
      trial = {res.rem, res.qn[R_W-1]};
      if (trial >= {1'b0, den}) begin
        res.rem = ACC_W'(trial - {1'b0, den});
        res.qn  = {res.qn[R_W-2:0], 1'b1};
      end else begin
        res.rem = trial[ACC_W-1:0];
        res.qn  = {res.qn[R_W-2:0], 1'b0};
      end
    end
    return res;
  endfunction

  // Rounded square of a value with 31 fraction bits.
  function automatic logic [R_W-1:0] square_q31(input logic [R_W-1:0] r);
    logic [2*R_W-1:0] prod;
    prod = (2*R_W)'(r) * (2*R_W)'(r) + SQ_HALF;
    return prod[SQ_FRAC +: R_W];
  endfunction

endpackage

// ===== rtl/erf_rational_approx.sv =====
// erf_rational_approx: erf(x) of a signed fixed-point sample, uses erf_ra_pkg and the macros.
// Throughput: one request per cycle while no stalled result holds the pipeline;
// every one of the 29 stages is its own register.
// The stages are 1 input stage, 6 Horner MACs, 16 divider stages of two quotient bits,
// 4 squarings, 1 rounding stage and 1 output stage.
// Reset (rst, synchronous): clears all stage valid bits; data registers are not reset.
`include "erf_rational_approx_macros.svh"

module erf_rational_approx #(
  parameter int INPUT_WIDTH  = erf_ra_pkg::DEF_INPUT_WIDTH,
  parameter int OUTPUT_WIDTH = erf_ra_pkg::DEF_OUTPUT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           x_valid,
  output logic                           x_stall,
  input  logic signed [INPUT_WIDTH-1:0]  x_value,
  output logic                           erf_valid,
  input  logic                           erf_stall,
  output logic signed [OUTPUT_WIDTH-1:0] erf_value
);

  import erf_ra_pkg::*;

  // Stage positions along the pipeline. Stage 0 registers the input decode,
  // the Horner steps follow, then the divider, the squarings, the rounding
  // stage and finally the output register.
  localparam int LAT      = 1 + HORNER_STEPS + DIV_STAGES + SQUARINGS + 2;
  localparam int DIV_LAST = HORNER_STEPS + DIV_STAGES;

  // Output rounding: the magnitude has 31 fraction bits and is brought down
  // to OUTPUT_WIDTH-1 fraction bits, rounding half up on the magnitude.
  localparam int SHIFT    = R_W - OUTPUT_WIDTH;
  localparam int HALF_POS = (SHIFT > 0) ? SHIFT - 1 : 0;
  localparam logic [R_W-1:0] HALF_LSB   = (SHIFT > 0) ? (R_W'(1) << HALF_POS) : '0;
  localparam logic [R_W-1:0] ROUND_BIAS = ONE_Q31 + HALF_LSB;

  localparam logic [OUTPUT_WIDTH-1:0] MAX_CODE = {1'b0, {(OUTPUT_WIDTH-1){1'b1}}};
  localparam logic [OUTPUT_WIDTH-1:0] MIN_CODE = {1'b1, {(OUTPUT_WIDTH-1){1'b0}}};

  // ------------------------------------------------------------------------
  // Flow control. The whole pipeline moves as one: it advances unless a
  // finished result sits in the output register and the consumer stalls it.
  // A stalled cycle freezes every stage, so nothing is lost or repeated.
  // ------------------------------------------------------------------------
  logic             adv;
  logic [LAT-1:0]   vld;
  side_t            side_q [LAT];

  assign x_stall   = erf_valid & erf_stall;
  assign adv       = ~x_stall;
  assign erf_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], x_valid};
    end
  end

  // ------------------------------------------------------------------------
  // Stage 0: sign extension, range test and absolute value. A saturating
  // sample sends zero down the arithmetic path so that the divisor stays at
  // one and the divider is never fed a meaningless operand.
  // ------------------------------------------------------------------------
  logic signed [XW-1:0] x_ext;
  logic [XW-1:0]        x_abs;
  side_t                a_side_next;
  logic [ZW-1:0]        a_z_next;
  logic [ZW-1:0]        a_z;

  always_comb begin
    x_ext               = XW'(x_value);
    a_side_next.neg     = x_ext[XW-1];
    a_side_next.sat_pos = x_ext > LIMIT_POS;
    a_side_next.sat_neg = x_ext < LIMIT_NEG;
    x_abs               = a_side_next.neg ? XW'(-x_ext) : XW'(x_ext);
    a_z_next            = (a_side_next.sat_pos || a_side_next.sat_neg) ? '0 : x_abs[ZW-1:0];
  end

  // ------------------------------------------------------------------------
  // Horner evaluation of q(z) = 1 + a1 z + ... + a6 z^6, one multiply and
  // accumulate per stage, highest coefficient first.
  // ------------------------------------------------------------------------
  logic [ZW-1:0]    hz        [HORNER_STEPS-1];
  logic [ACC_W-1:0] hacc      [HORNER_STEPS];
  logic [ZW-1:0]    h_z_in    [HORNER_STEPS];
  logic [ACC_W-1:0] h_acc_in  [HORNER_STEPS];
  logic [ACC_W-1:0] hacc_next [HORNER_STEPS];

  for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
    if (h == 0) begin : g_head
      assign h_z_in[h]   = a_z;
      assign h_acc_in[h] = COEF_Q32[HORNER_STEPS];
    end else begin : g_body
      assign h_z_in[h]   = hz[h-1];
      assign h_acc_in[h] = hacc[h-1];
    end
    assign hacc_next[h] = horner_step(h_z_in[h], h_acc_in[h], COEF_Q32[HORNER_STEPS-1-h]);
  end

  // ------------------------------------------------------------------------
  // Reciprocal r = floor((2^63 + q/2) / q), with 31 fraction bits, by a
  // restoring divider that settles two quotient bits per stage. The upper
  // half of the numerator is below the divisor, so 32 quotient bits suffice.
  // The remainder of the last stage is not needed and is not kept.
  // ------------------------------------------------------------------------
  logic [2*R_W-1:0] num0;
  logic [ACC_W-1:0] drem     [DIV_STAGES-1];
  logic [R_W-1:0]   dqn      [DIV_STAGES];
  logic [ACC_W-1:0] dden     [DIV_STAGES-1];
  logic [ACC_W-1:0] d_rem_in [DIV_STAGES];
  logic [R_W-1:0]   d_qn_in  [DIV_STAGES];
  logic [ACC_W-1:0] d_den_in [DIV_STAGES];
  div_t             div_next [DIV_STAGES];

  assign num0 = {1'b1, (2*R_W-1)'(0)} + (2*R_W)'(hacc[HORNER_STEPS-1] >> 1);

  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    if (d == 0) begin : g_head
      assign d_rem_in[d] = ACC_W'(num0[2*R_W-1:R_W]);
      assign d_qn_in[d]  = num0[R_W-1:0];
      assign d_den_in[d] = hacc[HORNER_STEPS-1];
    end else begin : g_body
      assign d_rem_in[d] = drem[d-1];
      assign d_qn_in[d]  = dqn[d-1];
      assign d_den_in[d] = dden[d-1];
    end
    assign div_next[d] = div_stage(d_rem_in[d], d_qn_in[d], d_den_in[d]);
  end

  // ------------------------------------------------------------------------
  // p = r^16 by four rounded squarings, one per stage.
  // ------------------------------------------------------------------------
  logic [R_W-1:0] sq      [SQUARINGS];
  logic [R_W-1:0] s_in    [SQUARINGS];
  logic [R_W-1:0] sq_next [SQUARINGS];

  for (genvar s = 0; s < SQUARINGS; s++) begin : g_square
    if (s == 0) begin : g_head
      assign s_in[s] = dqn[DIV_STAGES-1];
    end else begin : g_body
      assign s_in[s] = sq[s-1];
    end
    assign sq_next[s] = square_q31(s_in[s]);
  end

  // ------------------------------------------------------------------------
  // Rounding stage: magnitude 1 - p with half an output LSB added, then the
  // fraction cut down to the output width.
  // Output stage: saturation, sign and the clamp of a rounded +1.
  // Negating the rounded magnitude gives rounding half away from zero.
  // ------------------------------------------------------------------------
  logic [R_W-1:0]          m_sum;
  logic [OUTPUT_WIDTH-1:0] mround;
  logic [OUTPUT_WIDTH-1:0] out_next;
  side_t                   out_side;

  assign m_sum    = ROUND_BIAS - sq[SQUARINGS-1];
  assign out_side = side_q[LAT-2];

  always_comb begin
    if (out_side.sat_pos) begin
      out_next = MAX_CODE;
    end else if (out_side.sat_neg) begin
      out_next = MIN_CODE;
    end else if (out_side.neg) begin
      out_next = ~mround + OUTPUT_WIDTH'(1);
    end else if (mround[OUTPUT_WIDTH-1]) begin
      out_next = MAX_CODE;
    end else begin
      out_next = mround;
    end
  end

  // ------------------------------------------------------------------------
  // Data registers of every stage; they all move on the common advance.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      a_z       <= a_z_next;
      side_q[0] <= a_side_next;
      for (int i = 1; i < LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
      for (int h = 0; h < HORNER_STEPS - 1; h++) begin
        hz[h] <= h_z_in[h];
      end
      for (int h = 0; h < HORNER_STEPS; h++) begin
        hacc[h] <= hacc_next[h];
      end
      for (int d = 0; d < DIV_STAGES; d++) begin
        dqn[d] <= div_next[d].qn;
      end
      for (int d = 0; d < DIV_STAGES - 1; d++) begin
        drem[d] <= div_next[d].rem;
        dden[d] <= d_den_in[d];
      end
      for (int s = 0; s < SQUARINGS; s++) begin
        sq[s] <= sq_next[s];
      end
      mround    <= m_sum[SHIFT +: OUTPUT_WIDTH];
      erf_value <= out_next;
    end
  end

  // ------------------------------------------------------------------------
  // Checks. The sign of a result follows the sign of its sample, the
  // reciprocal never exceeds one, and a stalled pipeline holds its valid bits.
  // ------------------------------------------------------------------------
  `ERF_ASSERT_NOW(a_neg_sign, erf_valid && side_q[LAT-1].neg, !(erf_value > 0))
  `ERF_ASSERT_NOW(a_pos_sign, erf_valid && !side_q[LAT-1].neg, !erf_value[OUTPUT_WIDTH-1])
  `ERF_ASSERT_NOW(a_recip_bound, vld[DIV_LAST], dqn[DIV_STAGES-1] <= ONE_Q31)
  `ERF_ASSERT_NEXT(a_stall_hold, x_stall, $stable(vld))

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for erf_rational_approx: a directed table of requests, then
// random requests, each checked against the fixed-point erf predictor or the table.
// Depends on erf_ra_pkg for the default widths and on the RTL of erf_rational_approx.
module tb_top;

  localparam int IN_W  = erf_ra_pkg::DEF_INPUT_WIDTH;
  localparam int OUT_W = erf_ra_pkg::DEF_OUTPUT_WIDTH;

  // Six in Q3.12; beyond it in either direction the result saturates.
  localparam int SIX_CODE = 6 << 12;

  localparam logic signed [OUT_W-1:0] ERF_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] ERF_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam int RANDOM_REQUESTS  = 600;
  localparam int DIRECTED_ROWS    = 21;
  localparam int QUIET_TAIL       = 60;
  localparam int LONG_HOLD_AFTER  = 300;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int REPORT_LIMIT     = 10;

  // Polynomial coefficients a1 to a6 in units of 1e-10, as published.
  localparam longint unsigned COEF_E10 [6] = '{
    64'd705230784, 64'd422820123, 64'd92705272,
    64'd1520143,   64'd2765672,   64'd430638
  };

  typedef struct packed {
    logic signed [IN_W-1:0]  x;
    bit                      typed;
    logic signed [OUT_W-1:0] erf;
  } directed_row_t;

  typedef struct {
    logic signed [IN_W-1:0]  x;
    logic signed [OUT_W-1:0] erf;
  } erf_due_t;

  // Directed requests. Rows with typed set carry a result that is obvious by hand:
  // zero maps to zero and anything past six saturates. The rest go to the predictor.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'sd0,       1'b1, 16'sd0},
    '{16'sd32767,   1'b1, 16'sd32767},
    '{-16'sd32768,  1'b1, -16'sd32768},
    '{16'sd24577,   1'b1, 16'sd32767},
    '{-16'sd24577,  1'b1, -16'sd32768},
    '{16'sd24576,   1'b0, 16'sd0},
    '{-16'sd24576,  1'b0, 16'sd0},
    '{16'sd24575,   1'b0, 16'sd0},
    '{-16'sd24575,  1'b0, 16'sd0},
    '{16'sd1,       1'b0, 16'sd0},
    '{-16'sd1,      1'b0, 16'sd0},
    '{16'sd100,     1'b0, 16'sd0},
    '{-16'sd100,    1'b0, 16'sd0},
    '{16'sd2048,    1'b0, 16'sd0},
    '{-16'sd2048,   1'b0, 16'sd0},
    '{16'sd4096,    1'b0, 16'sd0},
    '{-16'sd4096,   1'b0, 16'sd0},
    '{16'sd12288,   1'b0, 16'sd0},
    '{-16'sd12288,  1'b0, 16'sd0},
    '{16'sd21845,   1'b0, 16'sd0},
    '{-16'sd21846,  1'b0, 16'sd0}
  };

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     x_valid   = 1'b0;
  logic                     x_stall;
  logic signed [IN_W-1:0]   x_value   = '0;
  logic                     erf_valid;
  logic                     erf_stall = 1'b0;
  logic signed [OUT_W-1:0]  erf_value;

  erf_due_t erf_due [$];
  int       mismatch_count  = 0;
  int       results_checked = 0;
  int       cycle_count     = 0;
  int       sender_calm     = 0;

  erf_rational_approx u_top (
    .clk       (clk),
    .rst       (rst),
    .x_valid   (x_valid),
    .x_stall   (x_stall),
    .x_value   (x_value),
    .erf_valid (erf_valid),
    .erf_stall (erf_stall),
    .erf_value (erf_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Coefficient k of the Horner polynomial as round(a * 2^32); a0 is exactly one.
  function automatic bit [63:0] horner_coef(input int k);
    if (k == 0) return 64'd1 << 32;
    return (COEF_E10[k-1] * 64'd4294967296 + 64'd5000000000) / 64'd10000000000;
  endfunction

  // Fixed-point erf of one sample. The Horner accumulator keeps 32 fraction bits,
  // the reciprocal of q and its powers keep 31, and the last step rounds the
  // magnitude to the output precision before the sign is applied.
  function automatic logic signed [OUT_W-1:0] erf_fixed(input logic signed [IN_W-1:0] x);
    bit [63:0] z;
    bit [63:0] acc;
    bit [63:0] r;
    bit [63:0] mag;
    if (x > SIX_CODE) return ERF_MAX;
    if (x < -SIX_CODE) return ERF_MIN;
    z   = 64'(x < 0 ? -int'(x) : int'(x));
    acc = horner_coef(6);
    for (int k = 5; k >= 0; k--) acc = horner_coef(k) + ((z * acc + 64'd2048) >> 12);
    r = ((64'd1 << 63) + (acc >> 1)) / acc;
    // Raising 1/q to the sixteenth power takes four rounded squarings.
    repeat (4) r = (r * r + (64'd1 << 30)) >> 31;
    mag = ((64'd1 << 31) - r + (64'd1 << 15)) >> 16;
    if (x < 0) begin
      if (mag > 64'd32768) mag = 64'd32768;
      return OUT_W'(64'd0 - mag);
    end
    if (mag > 64'd32767) mag = 64'd32767;
    return OUT_W'(mag);
  endfunction

  // Random samples lean on the polynomial range, with some weight near zero where
  // erf is steepest, near the two saturation edges, and across the whole code space.
  function automatic logic signed [IN_W-1:0] draw_sample();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      v = int'($urandom_range(0, 2 * SIX_CODE)) - SIX_CODE;
    end else if (pick < 75) begin
      v = int'($urandom_range(0, 1023)) - 512;
    end else if (pick < 85) begin
      v = SIX_CODE - 2 + int'($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = int'($urandom());
    end
    return IN_W'(v);
  endfunction

  // Offers one request and returns at the edge where it is accepted. The valid is
  // only lowered when an idle burst follows, so back-to-back requests keep it high.
  task automatic offer(input logic signed [IN_W-1:0]  x,
                       input bit                      typed,
                       input logic signed [OUT_W-1:0] typed_erf,
                       input bit                      may_idle);
    int       gap;
    erf_due_t due;
    gap = 0;
    if (sender_calm > 0) begin
      sender_calm--;
    end else if (may_idle) begin
      if ($urandom_range(0, 99) < 12) gap = $urandom_range(1, 10);
      else if ($urandom_range(0, 99) < 3) sender_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      x_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    x_valid <= 1'b1;
    x_value <= x;
    @(posedge clk);
    while (x_stall) @(posedge clk);
    due.x   = x;
    due.erf = typed ? typed_erf : erf_fixed(x);
    erf_due.push_back(due);
  endtask

  // Request side: reset, the directed table, then the random requests. Idling
  // stops for the last stretch so the pipeline also runs flat out.
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i]) offer(DIRECTED[i].x, DIRECTED[i].typed, DIRECTED[i].erf, 1'b1);
    for (int n = 0; n < RANDOM_REQUESTS; n++)
      offer(draw_sample(), 1'b0, '0, n < RANDOM_REQUESTS - QUIET_TAIL);
    x_valid <= 1'b0;
    while (erf_due.size() != 0) @(posedge clk);
    // The drain wait catches any result the block produces without a request.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d directed and %0d random requests; %0d results checked, %0d mismatches.",
             DIRECTED_ROWS, RANDOM_REQUESTS, results_checked, mismatch_count);
    $display("Included both saturations, the exact six boundary and a %0d-cycle output hold-off.",
             LONG_HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Result side. Stalls come in short random bursts with calm stretches between,
  // and once, midway, a long hold-off during which the request side keeps
  // offering, so the pipeline fills up and has to push back on its input.
  initial begin : receiver
    int seen_requests;
    int burst_left;
    int calm_left;
    bit long_hold_done;
    seen_requests  = 0;
    burst_left     = 0;
    calm_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (x_valid && !x_stall) seen_requests++;
      if (!long_hold_done && seen_requests >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        erf_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD_CYCLES; c++) begin
          @(posedge clk);
          if (x_valid && !x_stall) seen_requests++;
        end
        erf_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        erf_stall <= 1'b1;
      end else if (seen_requests < DIRECTED_ROWS + RANDOM_REQUESTS - QUIET_TAIL &&
                   calm_left == 0 && $urandom_range(0, 99) < 12) begin
        burst_left = $urandom_range(0, 9);
        erf_stall <= 1'b1;
      end else begin
        erf_stall <= 1'b0;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(30, 80);
      end
    end
  end

  // Every accepted result is matched against the oldest outstanding request.
  always @(posedge clk) begin : check_results
    erf_due_t due;
    if (!rst && erf_valid === 1'b1 && erf_stall === 1'b0) begin
      if (erf_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Result %0d arrived with no request outstanding.", erf_value);
      end else begin
        due = erf_due.pop_front();
        results_checked++;
        if (erf_value !== due.erf) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("erf_value mismatch for x_value %0d: expected %0d, got %0d.",
                     due.x, due.erf, erf_value);
        end
      end
    end
  end

  // Safety net against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, erf_due.size());
      $display("tb_top failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/erf_ra_pkg.sv
rtl/erf_rational_approx.sv
tb/sv/tb_top.sv
